// ----- hw/rtl/egress_snat_session_engine_assert.svh -----
// Assertion macros used by the engine's datapath.
`ifndef EGRESS_SNAT_SESSION_ENGINE_ASSERT_SVH
`define EGRESS_SNAT_SESSION_ENGINE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define SNAT_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("snat assertion failed");
// Next-cycle implication, checked outside reset.
`define SNAT_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("snat assertion failed");
`else
`define SNAT_ASSERT_IMP(label, clk, rstn, ante, cons)
`define SNAT_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

// ----- hw/rtl/snat_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package snat_pkg;

    localparam int unsigned SESSION_ENTRIES = 1024;
    localparam int unsigned RULE_ENTRIES    = 64;
    localparam int unsigned SIDX_W = (SESSION_ENTRIES > 1) ? $clog2(SESSION_ENTRIES) : 1;
    localparam int unsigned RIDX_W = (RULE_ENTRIES > 1) ? $clog2(RULE_ENTRIES) : 1;
    localparam int unsigned REC_W  = SIDX_W;
    localparam int unsigned CLR_COUNT =
        (SESSION_ENTRIES > RULE_ENTRIES) ? SESSION_ENTRIES : RULE_ENTRIES;
    localparam int unsigned CNT_W = $clog2(CLR_COUNT + 1);

    localparam logic [15:0] PORT_FIRST    = 16'd1024;
    localparam logic [15:0] PORT_ALL_ONES = 16'hFFFF;
    localparam logic [5:0]  ADDR_BITS     = 6'd32;
    localparam logic [15:0] ETH_IPV4      = 16'h0800;
    localparam logic [15:0] ETH_ARP       = 16'h0806;
    localparam logic [7:0]  PROTO_ICMP    = 8'd1;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;

    typedef enum logic [1:0] {
        VERDICT_PASS = 2'd0,
        VERDICT_TX   = 2'd1,
        VERDICT_DROP = 2'd2,
        VERDICT_RULE = 2'd3
    } verdict_t;

    typedef struct packed {
        logic        action;
        logic [15:0] ether_type;
        logic        headers_complete;
        logic [7:0]  ip_protocol;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [15:0] ip_checksum_in;
        logic [15:0] l4_checksum_in;
        logic [5:0]  rule_prefix_len;
        logic [31:0] rule_external_ip;
    } in_item_t;

    typedef struct packed {
        verdict_t    verdict;
        logic        nat_applied;
        logic        session_hit;
        logic [31:0] out_source_ip;
        logic [15:0] out_source_port;
        logic [15:0] out_ip_checksum;
        logic [15:0] out_l4_checksum;
    } out_item_t;

    typedef struct packed {
        logic             valid;
        logic [31:0]      src_ip;
        logic [31:0]      dst_ip;
        logic [39:0]      ports_proto;
        logic [47:0]      translation;
        logic [REC_W-1:0] recency;
    } sess_ent_t;

    typedef struct packed {
        logic        valid;
        logic [5:0]  len;
        logic [31:0] prefix;
        logic [31:0] ext_ip;
    } rule_ent_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_LOOKUP,
        ST_MATCH,
        ST_AGE,
        ST_LSCAN,
        ST_LWRITE,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        SCAN_NONE,
        SCAN_LOOKUP,
        SCAN_MATCH,
        SCAN_AGE,
        SCAN_LOAD
    } scan_t;

    typedef enum logic [2:0] {
        CLS_NAT,
        CLS_LOAD,
        CLS_LOAD_BAD,
        CLS_ARP,
        CLS_DROP
    } cls_t;

    typedef struct packed {
        logic     clear_wr;
        logic     load_in;
        logic     scan_init;
        logic     clr_cnt;
        scan_t    scan;
        logic     take_port;
        logic     rule_wr;
        logic     load_out;
        verdict_t out_verdict;
        logic     out_nat;
        logic     out_rule;
    } ctrl_cmd_t;

    typedef struct packed {
        cls_t cls;
        logic clear_done;
        logic scan_done;
        logic hit;
        logic best_found;
        logic load_slot_ok;
        logic out_free;
    } dp_status_t;

    function automatic logic [31:0] prefix_mask(input logic [5:0] len);
        logic [31:0] m;
        if (len == 6'd0) begin
            m = 32'h0;
        end else begin
            m = 32'hFFFF_FFFF << (ADDR_BITS - len);
        end
        return m;
    endfunction

    // Two end-around-carry folds and the final complement.
    function automatic logic [15:0] csum_fold(input logic [19:0] s);
        logic [16:0] s1;
        logic [15:0] s2;
        s1 = {1'b0, s[15:0]} + {13'd0, s[19:16]};
        s2 = s1[15:0] + {15'd0, s1[16]};
        return ~s2;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/snat_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "egress_snat_session_engine_assert.svh"
module snat_dp (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire snat_pkg::ctrl_cmd_t   cmd,
    output snat_pkg::dp_status_t       status,
    input  wire snat_pkg::in_item_t    s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output snat_pkg::out_item_t        m_data
);

    localparam logic [snat_pkg::CNT_W-1:0] SESS_LIM = snat_pkg::CNT_W'(snat_pkg::SESSION_ENTRIES);
    localparam logic [snat_pkg::CNT_W-1:0] RULE_LIM = snat_pkg::CNT_W'(snat_pkg::RULE_ENTRIES);
    localparam logic [snat_pkg::CNT_W-1:0] CLR_LAST = snat_pkg::CNT_W'(snat_pkg::CLR_COUNT - 1);

    snat_pkg::sess_ent_t sess_mem [snat_pkg::SESSION_ENTRIES];
    snat_pkg::rule_ent_t rule_mem [snat_pkg::RULE_ENTRIES];
    snat_pkg::sess_ent_t sess_q_reg;
    snat_pkg::rule_ent_t rule_q_reg;

    snat_pkg::in_item_t item_reg;
    logic [snat_pkg::CNT_W-1:0] cnt_reg, addr1_reg;
    logic vld1_reg;

    logic                        hit_reg;
    logic [snat_pkg::SIDX_W-1:0] hit_idx_reg;
    logic [snat_pkg::REC_W-1:0]  hit_rec_reg;
    logic                        free_found_reg;
    logic [snat_pkg::SIDX_W-1:0] free_idx_reg;
    logic [snat_pkg::SIDX_W-1:0] old_idx_reg;
    logic [snat_pkg::REC_W-1:0]  old_rec_reg;
    logic                        best_found_reg;
    logic [5:0]                  best_len_reg;
    logic [31:0]                 best_ext_reg;
    logic                        lsame_reg, lfree_reg;
    logic [snat_pkg::RIDX_W-1:0] lsame_idx_reg, lfree_idx_reg;
    logic [31:0]                 xlat_ip_reg;
    logic [15:0]                 xlat_port_reg;
    logic [15:0]                 next_port_reg;
    logic                        m_valid_reg;
    snat_pkg::out_item_t         m_data_reg;

    logic [snat_pkg::CNT_W-1:0]  lim;
    logic                        rd_en, sess_re, rule_re;
    logic [15:0]                 key_dport;
    logic [39:0]                 key_pp;
    logic [31:0]                 load_prefix;
    logic                        key_match, rule_hit;
    logic [snat_pkg::SIDX_W-1:0] addr1_s, age_slot;
    logic [snat_pkg::RIDX_W-1:0] addr1_r;
    logic                        age_all;
    logic [snat_pkg::REC_W-1:0]  age_lim;
    logic                        sess_we, rule_we;
    logic [snat_pkg::SIDX_W-1:0] sess_wa;
    logic [snat_pkg::RIDX_W-1:0] rule_wa;
    snat_pkg::sess_ent_t         sess_wd;
    snat_pkg::rule_ent_t         rule_wd;
    logic [15:0]                 port_pick;
    logic [17:0]                 addr_delta;
    logic [16:0]                 port_delta;
    logic [19:0]                 ip_sum, l4_sum;
    snat_pkg::out_item_t         out_next;

    always_comb begin
        case (cmd.scan)
            snat_pkg::SCAN_LOOKUP, snat_pkg::SCAN_AGE: lim = SESS_LIM;
            default:                                   lim = RULE_LIM;
        endcase
        rd_en   = (cmd.scan != snat_pkg::SCAN_NONE) && (cnt_reg < lim);
        sess_re = rd_en && ((cmd.scan == snat_pkg::SCAN_LOOKUP) ||
                            (cmd.scan == snat_pkg::SCAN_AGE));
        rule_re = rd_en && ((cmd.scan == snat_pkg::SCAN_MATCH) ||
                            (cmd.scan == snat_pkg::SCAN_LOAD));
        addr1_s = addr1_reg[snat_pkg::SIDX_W-1:0];
        addr1_r = addr1_reg[snat_pkg::RIDX_W-1:0];

        // ICMP keys use the echo identifier for both ports.
        key_dport = (item_reg.ip_protocol == snat_pkg::PROTO_ICMP) ?
                    item_reg.source_port : item_reg.dest_port;
        key_pp    = {item_reg.source_port, key_dport, item_reg.ip_protocol};
        key_match = sess_q_reg.valid && (sess_q_reg.src_ip == item_reg.source_ip) &&
                    (sess_q_reg.dst_ip == item_reg.dest_ip) &&
                    (sess_q_reg.ports_proto == key_pp);
        rule_hit  = rule_q_reg.valid &&
                    (((item_reg.source_ip ^ rule_q_reg.prefix) &
                      snat_pkg::prefix_mask(rule_q_reg.len)) == 32'h0);
        load_prefix = item_reg.source_ip & snat_pkg::prefix_mask(item_reg.rule_prefix_len);

        age_slot = hit_reg ? hit_idx_reg : (free_found_reg ? free_idx_reg : old_idx_reg);
        age_all  = !hit_reg && free_found_reg;
        age_lim  = hit_reg ? hit_rec_reg : old_rec_reg;

        sess_we = 1'b0;
        sess_wa = addr1_s;
        sess_wd = sess_q_reg;
        if (cmd.clear_wr) begin
            sess_we = (cnt_reg < SESS_LIM);
            sess_wa = cnt_reg[snat_pkg::SIDX_W-1:0];
            sess_wd = '0;
        end else if ((cmd.scan == snat_pkg::SCAN_AGE) && vld1_reg) begin
            if (addr1_s == age_slot) begin
                sess_we = 1'b1;
                if (hit_reg) begin
                    sess_wd.recency = '0;
                end else begin
                    sess_wd.valid       = 1'b1;
                    sess_wd.src_ip      = item_reg.source_ip;
                    sess_wd.dst_ip      = item_reg.dest_ip;
                    sess_wd.ports_proto = key_pp;
                    sess_wd.translation = {xlat_ip_reg, xlat_port_reg};
                    sess_wd.recency     = '0;
                end
            end else if (sess_q_reg.valid && (age_all || (sess_q_reg.recency < age_lim))) begin
                sess_we = 1'b1;
                sess_wd.recency = sess_q_reg.recency + 1'b1;
            end
        end

        rule_we = 1'b0;
        rule_wa = lsame_reg ? lsame_idx_reg : lfree_idx_reg;
        rule_wd = {1'b1, item_reg.rule_prefix_len, load_prefix, item_reg.rule_external_ip};
        if (cmd.clear_wr) begin
            rule_we = (cnt_reg < RULE_LIM);
            rule_wa = cnt_reg[snat_pkg::RIDX_W-1:0];
            rule_wd = '0;
        end else if (cmd.rule_wr) begin
            rule_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (sess_we) begin
            sess_mem[sess_wa] <= sess_wd;
        end
        if (sess_re) begin
            sess_q_reg <= sess_mem[cnt_reg[snat_pkg::SIDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (rule_we) begin
            rule_mem[rule_wa] <= rule_wd;
        end
        if (rule_re) begin
            rule_q_reg <= rule_mem[cnt_reg[snat_pkg::RIDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            vld1_reg <= 1'b0;
        end else begin
            vld1_reg <= rd_en;
            if (cmd.clr_cnt) begin
                cnt_reg <= '0;
            end else if (cmd.clear_wr || rd_en) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
        addr1_reg <= cnt_reg;
        if (cmd.load_in) begin
            item_reg <= s_data;
        end
    end

    // Scan bookkeeping: first hit, first free slot, oldest entry, best rule, rule load slot.
    // The translation comes from the hit entry, or from the best rule and a new port.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
            lsame_reg      <= 1'b0;
            lfree_reg      <= 1'b0;
        end else if (cmd.scan_init) begin
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
            lsame_reg      <= 1'b0;
            lfree_reg      <= 1'b0;
            old_idx_reg    <= '0;
            old_rec_reg    <= '0;
        end else if (cmd.take_port) begin
            xlat_ip_reg   <= best_ext_reg;
            xlat_port_reg <= port_pick;
        end else if (vld1_reg) begin
            case (cmd.scan)
                snat_pkg::SCAN_LOOKUP: begin
                    if (key_match && !hit_reg) begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= addr1_s;
                        hit_rec_reg <= sess_q_reg.recency;
                        xlat_ip_reg   <= sess_q_reg.translation[47:16];
                        xlat_port_reg <= sess_q_reg.translation[15:0];
                    end
                    if (!sess_q_reg.valid && !free_found_reg) begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= addr1_s;
                    end
                    if (sess_q_reg.recency > old_rec_reg) begin
                        old_rec_reg <= sess_q_reg.recency;
                        old_idx_reg <= addr1_s;
                    end
                end
                snat_pkg::SCAN_MATCH: begin
                    if (rule_hit && (!best_found_reg || (rule_q_reg.len > best_len_reg))) begin
                        best_found_reg <= 1'b1;
                        best_len_reg   <= rule_q_reg.len;
                        best_ext_reg   <= rule_q_reg.ext_ip;
                    end
                end
                snat_pkg::SCAN_LOAD: begin
                    if (rule_q_reg.valid && !lsame_reg &&
                        (rule_q_reg.len == item_reg.rule_prefix_len) &&
                        (rule_q_reg.prefix == load_prefix)) begin
                        lsame_reg     <= 1'b1;
                        lsame_idx_reg <= addr1_r;
                    end
                    if (!rule_q_reg.valid && !lfree_reg) begin
                        lfree_reg     <= 1'b1;
                        lfree_idx_reg <= addr1_r;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        port_pick = ((next_port_reg < snat_pkg::PORT_FIRST) ||
                     (next_port_reg == snat_pkg::PORT_ALL_ONES)) ?
                    snat_pkg::PORT_FIRST : next_port_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_port_reg <= snat_pkg::PORT_FIRST;
        end else if (cmd.take_port) begin
            next_port_reg <= port_pick + 16'd1;
        end
    end

    // Incremental checksum update with the old address and port removed and the new ones added.
    always_comb begin
        addr_delta = {2'b0, ~item_reg.source_ip[31:16]} + {2'b0, ~item_reg.source_ip[15:0]} +
                     {2'b0, xlat_ip_reg[31:16]} + {2'b0, xlat_ip_reg[15:0]};
        port_delta = {1'b0, ~item_reg.source_port} + {1'b0, xlat_port_reg};
        ip_sum = {4'b0, ~item_reg.ip_checksum_in} + {2'b0, addr_delta};
        if (item_reg.ip_protocol == snat_pkg::PROTO_ICMP) begin
            l4_sum = {4'b0, ~item_reg.l4_checksum_in} + {3'b0, port_delta};
        end else begin
            l4_sum = {4'b0, ~item_reg.l4_checksum_in} + {2'b0, addr_delta} +
                     {3'b0, port_delta};
        end

        out_next.verdict         = cmd.out_verdict;
        out_next.nat_applied     = 1'b0;
        out_next.session_hit     = 1'b0;
        out_next.out_source_ip   = item_reg.source_ip;
        out_next.out_source_port = item_reg.source_port;
        out_next.out_ip_checksum = item_reg.ip_checksum_in;
        out_next.out_l4_checksum = item_reg.l4_checksum_in;
        if (cmd.out_rule) begin
            out_next.out_source_ip   = '0;
            out_next.out_source_port = '0;
            out_next.out_ip_checksum = '0;
            out_next.out_l4_checksum = '0;
        end else if (cmd.out_nat) begin
            out_next.nat_applied     = 1'b1;
            out_next.session_hit     = hit_reg;
            out_next.out_source_ip   = xlat_ip_reg;
            out_next.out_source_port = xlat_port_reg;
            out_next.out_ip_checksum = snat_pkg::csum_fold(ip_sum);
            out_next.out_l4_checksum = snat_pkg::csum_fold(l4_sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.load_out) begin
            m_data_reg <= out_next;
        end
    end

    always_comb begin
        if (item_reg.action) begin
            status.cls = (item_reg.rule_prefix_len > snat_pkg::ADDR_BITS) ?
                         snat_pkg::CLS_LOAD_BAD : snat_pkg::CLS_LOAD;
        end else if (item_reg.ether_type == snat_pkg::ETH_ARP) begin
            status.cls = snat_pkg::CLS_ARP;
        end else if ((item_reg.ether_type != snat_pkg::ETH_IPV4) ||
                     !item_reg.headers_complete ||
                     ((item_reg.ip_protocol != snat_pkg::PROTO_TCP) &&
                      (item_reg.ip_protocol != snat_pkg::PROTO_UDP) &&
                      (item_reg.ip_protocol != snat_pkg::PROTO_ICMP))) begin
            status.cls = snat_pkg::CLS_DROP;
        end else begin
            status.cls = snat_pkg::CLS_NAT;
        end
        status.clear_done   = (cnt_reg == CLR_LAST);
        status.scan_done    = (cnt_reg == lim) && !vld1_reg;
        status.hit          = hit_reg;
        status.best_found   = best_found_reg;
        status.load_slot_ok = lsame_reg || lfree_reg;
        status.out_free     = !m_valid_reg || m_ready;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `SNAT_ASSERT_IMP(a_hit_excludes_rule, aclk, aresetn, hit_reg, !best_found_reg)
    `SNAT_ASSERT_IMP(a_age_has_cause, aclk, aresetn, cmd.scan == snat_pkg::SCAN_AGE, hit_reg || best_found_reg)
    `SNAT_ASSERT_NXT(a_port_in_range, aclk, aresetn, cmd.take_port, (xlat_port_reg >= snat_pkg::PORT_FIRST) && (xlat_port_reg != snat_pkg::PORT_ALL_ONES))

endmodule
`default_nettype wire

// ----- hw/rtl/snat_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module snat_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    output snat_pkg::ctrl_cmd_t        cmd,
    input  wire snat_pkg::dp_status_t  status
);

    snat_pkg::state_t   state_reg, state_next;
    snat_pkg::verdict_t res_verdict_reg, res_verdict_next;
    logic               res_nat_reg, res_nat_next;
    logic               res_rule_reg, res_rule_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= snat_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
        res_verdict_reg <= res_verdict_next;
        res_nat_reg     <= res_nat_next;
        res_rule_reg    <= res_rule_next;
    end

    always_comb begin
        state_next       = state_reg;
        res_verdict_next = res_verdict_reg;
        res_nat_next     = res_nat_reg;
        res_rule_next    = res_rule_reg;
        cmd              = '0;
        cmd.scan         = snat_pkg::SCAN_NONE;
        cmd.out_verdict  = res_verdict_reg;
        cmd.out_nat      = res_nat_reg;
        cmd.out_rule     = res_rule_reg;
        s_ready          = 1'b0;
        case (state_reg)
            snat_pkg::ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (status.clear_done) begin
                    state_next = snat_pkg::ST_IDLE;
                end
            end
            snat_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
                if (s_valid) begin
                    state_next = snat_pkg::ST_DECODE;
                end
            end
            snat_pkg::ST_DECODE: begin
                cmd.scan_init    = 1'b1;
                cmd.clr_cnt      = 1'b1;
                res_nat_next     = 1'b0;
                res_rule_next    = 1'b0;
                res_verdict_next = snat_pkg::VERDICT_TX;
                case (status.cls)
                    snat_pkg::CLS_LOAD:     state_next = snat_pkg::ST_LSCAN;
                    snat_pkg::CLS_LOAD_BAD: begin
                        res_verdict_next = snat_pkg::VERDICT_DROP;
                        res_rule_next    = 1'b1;
                        state_next       = snat_pkg::ST_FINISH;
                    end
                    snat_pkg::CLS_ARP: begin
                        res_verdict_next = snat_pkg::VERDICT_PASS;
                        state_next       = snat_pkg::ST_FINISH;
                    end
                    snat_pkg::CLS_DROP: begin
                        res_verdict_next = snat_pkg::VERDICT_DROP;
                        state_next       = snat_pkg::ST_FINISH;
                    end
                    default: state_next = snat_pkg::ST_LOOKUP;
                endcase
            end
            snat_pkg::ST_LOOKUP: begin
                cmd.scan = snat_pkg::SCAN_LOOKUP;
                if (status.scan_done) begin
                    cmd.clr_cnt = 1'b1;
                    if (status.hit) begin
                        res_nat_next = 1'b1;
                        state_next   = snat_pkg::ST_AGE;
                    end else begin
                        state_next = snat_pkg::ST_MATCH;
                    end
                end
            end
            snat_pkg::ST_MATCH: begin
                cmd.scan = snat_pkg::SCAN_MATCH;
                if (status.scan_done) begin
                    cmd.clr_cnt = 1'b1;
                    if (status.best_found) begin
                        cmd.take_port = 1'b1;
                        res_nat_next  = 1'b1;
                        state_next    = snat_pkg::ST_AGE;
                    end else begin
                        state_next = snat_pkg::ST_FINISH;
                    end
                end
            end
            snat_pkg::ST_AGE: begin
                cmd.scan = snat_pkg::SCAN_AGE;
                if (status.scan_done) begin
                    state_next = snat_pkg::ST_FINISH;
                end
            end
            snat_pkg::ST_LSCAN: begin
                cmd.scan      = snat_pkg::SCAN_LOAD;
                res_rule_next = 1'b1;
                if (status.scan_done) begin
                    if (status.load_slot_ok) begin
                        res_verdict_next = snat_pkg::VERDICT_RULE;
                        state_next       = snat_pkg::ST_LWRITE;
                    end else begin
                        res_verdict_next = snat_pkg::VERDICT_DROP;
                        state_next       = snat_pkg::ST_FINISH;
                    end
                end
            end
            snat_pkg::ST_LWRITE: begin
                cmd.rule_wr = 1'b1;
                state_next  = snat_pkg::ST_FINISH;
            end
            snat_pkg::ST_FINISH: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = snat_pkg::ST_IDLE;
                end
            end
            default: state_next = snat_pkg::ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ----- hw/rtl/egress_snat_session_engine.sv -----
// Egress source-NAT engine. Each request carries either the parsed headers of one
// packet or one source-NAT rule to load, and yields exactly one result. After reset the
// engine first runs a clearing pass over the session and rule memories, covering
// max(SESSION_ENTRIES, RULE_ENTRIES) entries (1024 with the default sizes); no
// request is taken during that time. Requests are then handled one at a time, and the
// time per request is set by sweeps over the session and rule memories, one entry per
// cycle. ARP, dropped packets and rules with an illegal prefix length go straight from
// decode to the result. A packet with a session hit needs a lookup sweep, then a
// recency update sweep. A miss needs a lookup sweep and a rule match sweep, and another
// sweep of the session table to insert the new session when a rule matches. A rule load
// needs one rule table sweep, then the write if a slot is found. The result sits in an
// output register, so the next request is accepted while the previous result waits.
`timescale 1ns / 1ps
`default_nettype none
module egress_snat_session_engine (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire snat_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output snat_pkg::out_item_t      m_data
);

    // Commands from the sequencer into the datapath, status flags back.
    snat_pkg::ctrl_cmd_t  cmd;
    snat_pkg::dp_status_t status;

    // The sequencer owns the request handshake and steps through the memory sweeps.
    snat_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // The datapath holds the session and rule memories, the port counter, the
    // checksum update and the output register.
    snat_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (status),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire

// ----- sim/egress_snat_session_engine_tb.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Keeps a bit-level copy of the session table, the rule table and the port
// counter, and predicts the result of every request accepted by the engine.
class snat_scoreboard;
    localparam int NSESS = snat_pkg::SESSION_ENTRIES;
    localparam int NRULE = snat_pkg::RULE_ENTRIES;

    bit [31:0] s_sip[NSESS];
    bit [31:0] s_dip[NSESS];
    bit [39:0] s_key[NSESS];
    bit [47:0] s_xlat[NSESS];
    bit        s_used[NSESS];
    int unsigned s_age[NSESS];
    bit [31:0] r_prefix[NRULE];
    bit [31:0] r_ext[NRULE];
    bit [5:0]  r_len[NRULE];
    bit        r_used[NRULE];
    bit [15:0] port_ctr;
    snat_pkg::out_item_t pending[$];
    int errors;

    function new();
        for (int i = 0; i < NSESS; i++) begin
            s_used[i] = 0;
            s_age[i] = 0;
        end
        for (int i = 0; i < NRULE; i++) r_used[i] = 0;
        port_ctr = snat_pkg::PORT_FIRST;
        errors = 0;
    endfunction

    function bit [31:0] mask_of(bit [5:0] len);
        if (len == 0) return 32'h0;
        return 32'hFFFF_FFFF << (32 - len);
    endfunction

    function bit [15:0] fold(bit [31:0] s);
        s = (s & 32'hFFFF) + (s >> 16);
        s = (s & 32'hFFFF) + (s >> 16);
        return ~s[15:0];
    endfunction

    function void grow_older(int unsigned limit, int skip);
        for (int i = 0; i < NSESS; i++)
            if (s_used[i] && i != skip && s_age[i] < limit) s_age[i]++;
    endfunction

    function void add_session(bit [31:0] sip, bit [31:0] dip, bit [39:0] key,
                              bit [47:0] xl);
        int slot;
        slot = -1;
        for (int i = 0; i < NSESS; i++)
            if (!s_used[i]) begin
                slot = i;
                break;
            end
        if (slot >= 0) begin
            grow_older(32'hFFFF_FFFF, slot);
        end else begin
            slot = 0;
            for (int i = 0; i < NSESS; i++) if (s_age[i] > s_age[slot]) slot = i;
            grow_older(s_age[slot], slot);
        end
        s_sip[slot] = sip;
        s_dip[slot] = dip;
        s_key[slot] = key;
        s_xlat[slot] = xl;
        s_used[slot] = 1;
        s_age[slot] = 0;
    endfunction

    function snat_pkg::verdict_t store_rule(bit [31:0] pfx, bit [5:0] len, bit [31:0] ext);
        int slot;
        slot = -1;
        if (len > 32) return snat_pkg::VERDICT_DROP;
        pfx &= mask_of(len);
        for (int i = 0; i < NRULE; i++)
            if (r_used[i] && r_len[i] == len && r_prefix[i] == pfx) begin
                slot = i;
                break;
            end
        if (slot < 0)
            for (int i = 0; i < NRULE; i++)
                if (!r_used[i]) begin
                    slot = i;
                    break;
                end
        if (slot < 0) return snat_pkg::VERDICT_DROP;
        r_prefix[slot] = pfx;
        r_ext[slot] = ext;
        r_len[slot] = len;
        r_used[slot] = 1;
        return snat_pkg::VERDICT_RULE;
    endfunction

    // Notes an accepted request and queues the result it must produce.
    function void note_request(snat_pkg::in_item_t rq);
        snat_pkg::out_item_t r;
        bit [15:0] dport, nport;
        bit [31:0] nip, adelta, pdelta;
        bit [39:0] key;
        bit nat, hit;
        int best;
        r = '0;
        if (rq.action) begin
            r.verdict = store_rule(rq.source_ip, rq.rule_prefix_len, rq.rule_external_ip);
            pending.push_back(r);
            return;
        end
        r.out_source_ip = rq.source_ip;
        r.out_source_port = rq.source_port;
        r.out_ip_checksum = rq.ip_checksum_in;
        r.out_l4_checksum = rq.l4_checksum_in;
        if (rq.ether_type == snat_pkg::ETH_ARP) begin
            r.verdict = snat_pkg::VERDICT_PASS;
            pending.push_back(r);
            return;
        end
        if (rq.ether_type != snat_pkg::ETH_IPV4 || !rq.headers_complete ||
            !(rq.ip_protocol == snat_pkg::PROTO_TCP || rq.ip_protocol == snat_pkg::PROTO_UDP
              || rq.ip_protocol == snat_pkg::PROTO_ICMP)) begin
            r.verdict = snat_pkg::VERDICT_DROP;
            pending.push_back(r);
            return;
        end
        // For ICMP the echo identifier fills both port slots of the key.
        dport = (rq.ip_protocol == snat_pkg::PROTO_ICMP) ? rq.source_port : rq.dest_port;
        key = {rq.source_port, dport, rq.ip_protocol};
        nat = 0;
        hit = 0;
        nip = 0;
        nport = 0;
        for (int i = 0; i < NSESS; i++)
            if (s_used[i] && s_sip[i] == rq.source_ip && s_dip[i] == rq.dest_ip &&
                s_key[i] == key) begin
                hit = 1;
                nat = 1;
                nip = s_xlat[i][47:16];
                nport = s_xlat[i][15:0];
                grow_older(s_age[i], i);
                s_age[i] = 0;
                break;
            end
        if (!hit) begin
            best = -1;
            for (int i = 0; i < NRULE; i++)
                if (r_used[i] && ((rq.source_ip ^ r_prefix[i]) & mask_of(r_len[i])) == 0 &&
                    (best < 0 || r_len[i] > r_len[best])) best = i;
            if (best >= 0) begin
                nat = 1;
                nip = r_ext[best];
                if (port_ctr < snat_pkg::PORT_FIRST || port_ctr == snat_pkg::PORT_ALL_ONES)
                    port_ctr = snat_pkg::PORT_FIRST;
                nport = port_ctr;
                port_ctr = port_ctr + 16'd1;
                add_session(rq.source_ip, rq.dest_ip, key, {nip, nport});
            end
        end
        if (nat) begin
            adelta = {16'd0, ~rq.source_ip[31:16]} + {16'd0, ~rq.source_ip[15:0]}
                   + nip[31:16] + nip[15:0];
            pdelta = {16'd0, ~rq.source_port} + nport;
            r.out_source_ip = nip;
            r.out_source_port = nport;
            r.out_ip_checksum = fold({16'd0, ~rq.ip_checksum_in} + adelta);
            if (rq.ip_protocol == snat_pkg::PROTO_ICMP)
                r.out_l4_checksum = fold({16'd0, ~rq.l4_checksum_in} + pdelta);
            else
                r.out_l4_checksum = fold({16'd0, ~rq.l4_checksum_in} + adelta + pdelta);
        end
        r.verdict = snat_pkg::VERDICT_TX;
        r.nat_applied = nat;
        r.session_hit = hit;
        pending.push_back(r);
    endfunction

    task report(string what, longint got, longint want);
        $display("result error: %s got %0h expected %0h", what, got, want);
        errors++;
    endtask

    // Compares one accepted result against the oldest prediction.
    task check_result(snat_pkg::out_item_t got);
        snat_pkg::out_item_t w;
        if (pending.size() == 0) begin
            report("unexpected result", longint'(got.verdict), 0);
            return;
        end
        w = pending.pop_front();
        if (got.verdict != w.verdict) report("verdict", got.verdict, w.verdict);
        if (got.nat_applied != w.nat_applied)
            report("nat_applied", got.nat_applied, w.nat_applied);
        if (got.session_hit != w.session_hit)
            report("session_hit", got.session_hit, w.session_hit);
        if (got.out_source_ip != w.out_source_ip)
            report("out_source_ip", got.out_source_ip, w.out_source_ip);
        if (got.out_source_port != w.out_source_port)
            report("out_source_port", got.out_source_port, w.out_source_port);
        if (got.out_ip_checksum != w.out_ip_checksum)
            report("out_ip_checksum", got.out_ip_checksum, w.out_ip_checksum);
        if (got.out_l4_checksum != w.out_l4_checksum)
            report("out_l4_checksum", got.out_l4_checksum, w.out_l4_checksum);
    endtask
endclass

module egress_snat_session_engine_tb;

    // A session hit sweeps the table twice, and a miss with a rule match sweeps it twice
    // as well as the rule table; about 1800 requests at that worst case plus stalls and
    // the clearing pass after reset fit well within this limit.
    localparam longint CYCLE_LIMIT = 64'd20_000_000;
    localparam int N_RANDOM = 1800;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    snat_pkg::in_item_t  s_data;
    logic                m_valid;
    logic                m_ready;
    snat_pkg::out_item_t m_data;

    snat_scoreboard nat_model;
    longint    cycle_count;

    // A small pool of flows, so that random traffic revisits sessions and hits.
    bit [31:0] flow_sip[16];
    bit [31:0] flow_dip[16];
    bit [15:0] flow_sport[16];
    bit [15:0] flow_dport[16];
    bit [7:0]  flow_proto[16];

    egress_snat_session_engine i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // The watchdog ends the run, reported as a mismatch, once the cycle limit is reached.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("egress_snat_session_engine: mismatch");
            $finish;
        end
    end

    // Results are checked at the edge where they are taken.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) nat_model.check_result(m_data);
    end

    // The receiver may hold m_ready low for a random stall before taking each result.
    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            stall = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6));
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk iff m_valid);
        end
    end

    // Holds one request on the bus until it is accepted, after a random gap.
    task automatic send_request(snat_pkg::in_item_t rq);
        int gap;
        gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6));
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= rq;
        @(posedge aclk iff s_ready);
        nat_model.note_request(rq);
    endtask

    function automatic snat_pkg::in_item_t noise_item();
        snat_pkg::in_item_t rq;
        rq = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return rq;
    endfunction

    function automatic snat_pkg::in_item_t packet(bit [7:0] proto, bit [31:0] sip,
                                                  bit [31:0] dip, bit [15:0] sp,
                                                  bit [15:0] dp);
        snat_pkg::in_item_t rq;
        rq = noise_item();
        rq.action = 1'b0;
        rq.ether_type = snat_pkg::ETH_IPV4;
        rq.headers_complete = 1'b1;
        rq.ip_protocol = proto;
        rq.source_ip = sip;
        rq.dest_ip = dip;
        rq.source_port = sp;
        rq.dest_port = dp;
        return rq;
    endfunction

    function automatic snat_pkg::in_item_t rule_item(bit [31:0] pfx, bit [5:0] len,
                                                     bit [31:0] ext);
        snat_pkg::in_item_t rq;
        rq = noise_item();
        rq.action = 1'b1;
        rq.source_ip = pfx;
        rq.rule_prefix_len = len;
        rq.rule_external_ip = ext;
        return rq;
    endfunction

    function automatic bit [7:0] pick_proto();
        case ($urandom_range(0, 2))
            0: return snat_pkg::PROTO_TCP;
            1: return snat_pkg::PROTO_UDP;
            default: return snat_pkg::PROTO_ICMP;
        endcase
    endfunction

    initial begin : stimulus
        snat_pkg::in_item_t rq;
        int k, f;
        nat_model = new();
        cycle_count = 0;
        s_valid = 1'b0;
        s_data = '0;
        aresetn = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: before any rule, packets go out untouched.
        send_request(packet(snat_pkg::PROTO_TCP, 32'h0A00_0001, 32'h0808_0808, 16'd5000,
                            16'd80));
        rq = noise_item();
        rq.action = 1'b0;
        rq.ether_type = snat_pkg::ETH_ARP;
        rq.headers_complete = 1'b0;
        send_request(rq);
        rq = packet(snat_pkg::PROTO_UDP, 32'h0A00_0002, 32'h1, 16'd1, 16'd2);
        rq.headers_complete = 1'b0;
        send_request(rq);
        rq = packet(snat_pkg::PROTO_TCP, 32'h0A00_0002, 32'h1, 16'd1, 16'd2);
        rq.ether_type = 16'h86DD;
        send_request(rq);
        send_request(packet(8'd47, 32'h0A00_0003, 32'h2, 16'd3, 16'd4));
        send_request(packet(8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
        // Rules: illegal length, default route, longer prefixes, replacement.
        send_request(rule_item(32'hFFFF_FFFF, 6'd33, 32'h1));
        send_request(rule_item(32'hFFFF_FFFF, 6'd63, 32'h1));
        send_request(rule_item(32'hDEAD_BEEF, 6'd0, 32'hC633_6401));
        send_request(rule_item(32'h0AFF_FFFF, 6'd8, 32'hC633_6402));
        send_request(rule_item(32'h0A00_0005, 6'd32, 32'hFFFF_FFFF));
        send_request(rule_item(32'h0A12_3456, 6'd8, 32'hC633_6403));
        // Matches: then the same flows hit their sessions.
        rq = packet(snat_pkg::PROTO_TCP, 32'h0A00_0001, 32'h0808_0808, 16'd5000, 16'd80);
        rq.ip_checksum_in = 16'h0000;
        rq.l4_checksum_in = 16'hFFFF;
        send_request(rq);
        send_request(rq);
        rq = packet(snat_pkg::PROTO_UDP, 32'h0A00_0005, 32'h0, 16'h0, 16'hFFFF);
        rq.l4_checksum_in = 16'h0000;
        send_request(rq);
        send_request(packet(snat_pkg::PROTO_ICMP, 32'hC000_0001, 32'h0101_0101, 16'h1234,
                            16'hAAAA));
        send_request(packet(snat_pkg::PROTO_ICMP, 32'hC000_0001, 32'h0101_0101, 16'h1234,
                            16'h5555));
        send_request(packet(snat_pkg::PROTO_ICMP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                            16'h0));
        send_request(rule_item(32'h0, 6'd32, 32'h0));
        send_request(packet(snat_pkg::PROTO_UDP, 32'h0, 32'h0, 16'h0, 16'h0));

        // Random part: mostly flows from the pool, some random packets, rule loads and noise.
        for (int i = 0; i < 16; i++) begin
            flow_sip[i] = ($urandom_range(0, 1) ? {8'h0A, 24'($urandom)} : $urandom);
            flow_dip[i] = $urandom;
            flow_sport[i] = 16'($urandom);
            flow_dport[i] = 16'($urandom);
            flow_proto[i] = pick_proto();
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            k = $urandom_range(0, 99);
            if (k < 60) begin
                f = $urandom_range(0, 15);
                rq = packet(flow_proto[f], flow_sip[f], flow_dip[f], flow_sport[f],
                            flow_dport[f]);
                if (flow_proto[f] == snat_pkg::PROTO_ICMP) rq.dest_port = 16'($urandom);
            end else if (k < 80) begin
                rq = packet(pick_proto(), $urandom, $urandom, 16'($urandom), 16'($urandom));
            end else if (k < 88) begin
                rq = rule_item($urandom, 6'($urandom_range(0, 34)), $urandom);
                if ($urandom_range(0, 7) == 0) rq.rule_prefix_len = 6'($urandom);
            end else if (k < 92) begin
                rq = noise_item();
                rq.action = 1'b0;
                rq.ether_type = ($urandom_range(0, 1) ? snat_pkg::ETH_ARP :
                                 snat_pkg::ETH_IPV4);
            end else begin
                rq = noise_item();
            end
            send_request(rq);
        end
        s_valid <= 1'b0;

        // Drain: every result must arrive, then allow a little settling time.
        while (nat_model.pending.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (nat_model.errors == 0) begin
            $display("egress_snat_session_engine: match");
        end else begin
            $display("egress_snat_session_engine: mismatch");
        end
        $finish;
    end
endmodule
`default_nettype wire
